FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imh assertion failed");

// Next-cycle implication, disabled during reset
`define IMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imh assertion failed");

`endif

FILE: hw/rtl/imh_pkg.sv
// Package: widths, codes and controller/datapath types of the indexed min-heap
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

  localparam int IMH_MAX_ITEMS     = 256;
  localparam int IMH_PRIORITY_BITS = 32;
  localparam int FUNC_W            = 2;
  localparam int KEY_W             = 8;
  localparam int PRIO_IN_W         = 32;
  localparam int STATUS_W          = 3;
  localparam int COUNT_W           = 9;
  localparam int KEY_SPACE         = 2 ** KEY_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 2'd0,
    FN_DELETE   = 2'd1,
    FN_DECREASE = 2'd2,
    FN_CONTAINS = 2'd3
  } imh_func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_KEY   = 3'd3,
    ST_NODEC = 3'd4
  } imh_status_t;

  typedef enum logic [2:0] {
    RD_ROOT   = 3'd0,
    RD_LAST   = 3'd1,
    RD_MAP    = 3'd2,
    RD_PARENT = 3'd3,
    RD_LEFT   = 3'd4,
    RD_RIGHT  = 3'd5
  } imh_rd_sel_t;

  typedef struct packed {
    logic        in_rdy;
    logic        heap_rd;
    imh_rd_sel_t heap_rd_sel;
    logic        map_rd;
    logic        ins_begin;
    logic        root_cap;
    logic        del_take;
    logic        dec_take;
    logic        set_e;
    logic        up_move;
    logic        dn_left;
    logic        dn_right;
    logic        dn_move;
    logic        place;
    logic        st_load;
    imh_status_t st_code;
    logic        publish;
  } imh_cmd_t;

  typedef struct packed {
    logic      in_valid;
    imh_func_t func;
    logic      full;
    logic      hit;
    logic      empty;
    logic      last_one;
    logic      p_root;
    logic      up_greater;
    logic      dec_ok;
    logic      leaf;
    logic      has_right;
    logic      right_smaller;
    logic      down_greater;
    logic      out_busy;
  } imh_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/imh_if.sv
// Valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
`default_nettype none
interface imh_in_if import imh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [KEY_W-1:0]     item_key;
  logic [PRIO_IN_W-1:0] item_priority;

  modport source (output valid, func, item_key, item_priority, input ready);
  modport sink   (input valid, func, item_key, item_priority, output ready);
endinterface

interface imh_out_if import imh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KEY_W-1:0]     out_key;
  logic [PRIO_IN_W-1:0] out_priority;
  logic                 present;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   count;

  modport source (output valid, out_key, out_priority, present, status, count, input ready);
  modport sink   (input valid, out_key, out_priority, present, status, count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/indexed_min_heap_decrease_key.sv
// Top level: indexed binary min-heap with insert, delete-min, decrease and contains
// One request is in flight at a time. Insert and decrease climb the heap a level
// at a time by reading the parent (decrease first looks up the key's position in
// the map); delete-min first reads the root and the last entry, then descends,
// reading the left child and, if there is one, the right child at each level.
// The sift pace is set by the heap memory's single read port, which fetches the
// parent or each child in turn. The result register frees the input side as
// soon as a result is stored; a new request may be taken while an old result is
// still untaken, and only its own result waits for the old one. Keys index a
// 256-entry position map backed by per-key valid flops, so reset clears it at once and no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_decrease_key import imh_pkg::*; #(
  parameter int MAX_ITEMS     = IMH_MAX_ITEMS,
  parameter int PRIORITY_BITS = IMH_PRIORITY_BITS
) (
  input wire logic  clk,
  input wire logic  rst_n,
  imh_in_if.sink    in_ch,
  imh_out_if.source out_ch
);

  imh_cmd_t cmd;
  imh_sts_t sts;

  imh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  imh_dp #(
    .MAX_ITEMS     (MAX_ITEMS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/imh_ram.sv
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/imh_dp.sv
// Datapath: heap and key-map memories, working registers and result register
`timescale 1ns / 1ps
`default_nettype none
module imh_dp import imh_pkg::*; #(
  parameter int MAX_ITEMS     = IMH_MAX_ITEMS,
  parameter int PRIORITY_BITS = IMH_PRIORITY_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  imh_in_if.sink        in_ch,
  imh_out_if.source     out_ch,
  input  wire imh_cmd_t cmd,
  output      imh_sts_t sts
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int POS_W = $clog2(MAX_ITEMS + 1);
  localparam int CW    = POS_W + 1;
  localparam int PW    = PRIORITY_BITS;
  localparam int EW    = KEY_W + PW;

  imh_func_t           func_r;
  logic [KEY_W-1:0]    key_r;
  logic [PW-1:0]       prio_r;
  logic [POS_W-1:0]    count_r;
  logic [KEY_SPACE-1:0] valid_r;
  logic [POS_W-1:0]    pos_r;
  logic [KEY_W-1:0]    ekey_r;
  logic [PW-1:0]       eprio_r;
  logic [KEY_W-1:0]    ckey_r;
  logic [PW-1:0]       cprio_r;
  logic [POS_W-1:0]    cidx_r;
  logic [KEY_W-1:0]    rkey_r;
  logic [PW-1:0]       rprio_r;
  imh_status_t         status_r;

  logic                 out_valid_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [PRIO_IN_W-1:0] out_prio_r;
  logic                 out_present_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic [PW-1:0]        in_prio;
  logic [PRIO_IN_W-1:0] rprio_ext;
  logic [COUNT_W-1:0]   count_ext;
  logic                 accept;

  logic [EW-1:0]    heap_rdata;
  logic [KEY_W-1:0] hrd_key;
  logic [PW-1:0]    hrd_prio;
  logic [POS_W-1:0] map_rdata;
  logic [CW-1:0]    child;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    rd_idx_m1;
  logic [POS_W-1:0] wr_idx_m1;
  logic             heap_we;
  logic [EW-1:0]    heap_wdata;
  logic [KEY_W-1:0] map_wkey;

  generate
    if (PW <= PRIO_IN_W) begin : g_prio_narrow
      assign in_prio   = in_ch.item_priority[PW-1:0];
      assign rprio_ext = {{(PRIO_IN_W - PW){1'b0}}, rprio_r};
    end else begin : g_prio_wide
      assign in_prio   = {{(PW - PRIO_IN_W){1'b0}}, in_ch.item_priority};
      assign rprio_ext = rprio_r[PRIO_IN_W-1:0];
    end
    if (POS_W >= COUNT_W) begin : g_cnt_trunc
      assign count_ext = count_r[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign count_ext = {{(COUNT_W - POS_W){1'b0}}, count_r};
    end
  endgenerate

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = cmd.in_rdy;

  assign hrd_key  = heap_rdata[EW-1:PW];
  assign hrd_prio = heap_rdata[PW-1:0];
  assign child    = {pos_r, 1'b0};

  always_comb begin
    case (cmd.heap_rd_sel)
      RD_ROOT:   rd_idx = CW'(1);
      RD_LAST:   rd_idx = {1'b0, count_r};
      RD_MAP:    rd_idx = {1'b0, map_rdata};
      RD_PARENT: rd_idx = {2'b00, pos_r[POS_W-1:1]};
      RD_LEFT:   rd_idx = child;
      RD_RIGHT:  rd_idx = {pos_r, 1'b1};
      default:   rd_idx = CW'(1);
    endcase
  end

  assign rd_idx_m1 = rd_idx - CW'(1);
  assign wr_idx_m1 = pos_r - POS_W'(1);
  assign heap_we   = cmd.place || cmd.up_move || cmd.dn_move;

  always_comb begin
    if (cmd.up_move) begin
      heap_wdata = heap_rdata;
      map_wkey   = hrd_key;
    end else if (cmd.dn_move) begin
      heap_wdata = {ckey_r, cprio_r};
      map_wkey   = ckey_r;
    end else begin
      heap_wdata = {ekey_r, eprio_r};
      map_wkey   = ekey_r;
    end
  end

  imh_ram #(.WIDTH(EW), .DEPTH(MAX_ITEMS)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (wr_idx_m1[AW-1:0]),
    .wdata (heap_wdata),
    .re    (cmd.heap_rd),
    .raddr (rd_idx_m1[AW-1:0]),
    .rdata (heap_rdata)
  );

  imh_ram #(.WIDTH(POS_W), .DEPTH(KEY_SPACE)) u_map_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (map_wkey),
    .wdata (pos_r),
    .re    (cmd.map_rd),
    .raddr (key_r),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.ins_begin) begin
        count_r <= count_r + POS_W'(1);
      end else if (cmd.del_take) begin
        count_r <= count_r - POS_W'(1);
      end
      if (heap_we) begin
        valid_r[map_wkey] <= 1'b1;
      end else if (cmd.del_take) begin
        valid_r[rkey_r] <= 1'b0;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= imh_func_t'(in_ch.func);
      key_r    <= in_ch.item_key;
      prio_r   <= in_prio;
      rkey_r   <= '0;
      rprio_r  <= '0;
      status_r <= ST_OK;
    end
    if (cmd.st_load) begin
      status_r <= cmd.st_code;
    end
    if (cmd.ins_begin) begin
      pos_r   <= count_r + POS_W'(1);
      ekey_r  <= key_r;
      eprio_r <= prio_r;
    end
    if (cmd.set_e) begin
      ekey_r  <= key_r;
      eprio_r <= prio_r;
    end
    if (cmd.root_cap) begin
      rkey_r  <= hrd_key;
      rprio_r <= hrd_prio;
    end
    if (cmd.del_take) begin
      ekey_r  <= hrd_key;
      eprio_r <= hrd_prio;
      pos_r   <= POS_W'(1);
    end
    if (cmd.dec_take) begin
      pos_r <= map_rdata;
    end
    if (cmd.up_move) begin
      pos_r <= pos_r >> 1;
    end
    if (cmd.dn_left) begin
      ckey_r  <= hrd_key;
      cprio_r <= hrd_prio;
      cidx_r  <= child[POS_W-1:0];
    end
    if (cmd.dn_right) begin
      ckey_r  <= hrd_key;
      cprio_r <= hrd_prio;
      cidx_r  <= cidx_r + POS_W'(1);
    end
    if (cmd.dn_move) begin
      pos_r <= cidx_r;
    end
    if (cmd.publish) begin
      out_key_r     <= rkey_r;
      out_prio_r    <= rprio_ext;
      out_present_r <= (func_r == FN_CONTAINS) && (count_r != '0) && valid_r[key_r];
      out_status_r  <= status_r;
      out_count_r   <= count_ext;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_key      = out_key_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.present      = out_present_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.count        = out_count_r;

  assign sts.in_valid      = in_ch.valid;
  assign sts.func          = func_r;
  assign sts.full          = (count_r == POS_W'(MAX_ITEMS));
  assign sts.hit           = valid_r[key_r];
  assign sts.empty         = (count_r == '0);
  assign sts.last_one      = (count_r == POS_W'(1));
  assign sts.p_root        = (pos_r == POS_W'(1));
  assign sts.up_greater    = (hrd_prio > eprio_r);
  assign sts.dec_ok        = (prio_r < hrd_prio);
  assign sts.leaf          = (child > {1'b0, count_r});
  assign sts.has_right     = (child < {1'b0, count_r});
  assign sts.right_smaller = (cprio_r > hrd_prio);
  assign sts.down_greater  = (eprio_r > cprio_r);
  assign sts.out_busy      = out_valid_r && !out_ch.ready;

endmodule
`default_nettype wire

FILE: hw/rtl/imh_ctrl.sv
// Controller: sequences each request through checks, sift-up and sift-down
`timescale 1ns / 1ps
`default_nettype none
module imh_ctrl import imh_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire imh_sts_t sts,
  output      imh_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CHECK = 13'b0000000000010,
    S_DEL1  = 13'b0000000000100,
    S_DEL2  = 13'b0000000001000,
    S_DEC1  = 13'b0000000010000,
    S_DEC2  = 13'b0000000100000,
    S_UP    = 13'b0000001000000,
    S_UPW   = 13'b0000010000000,
    S_DOWN  = 13'b0000100000000,
    S_DNL   = 13'b0001000000000,
    S_DNR   = 13'b0010000000000,
    S_DNC   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } imh_state_t;

  imh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.func)
          FN_INSERT: begin
            if (sts.full) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_FULL;
              state_nxt   = S_DONE;
            end else if (sts.hit) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_KEY;
              state_nxt   = S_DONE;
            end else begin
              cmd.ins_begin = 1'b1;
              state_nxt     = S_UP;
            end
          end
          FN_DELETE: begin
            if (sts.empty) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_EMPTY;
              state_nxt   = S_DONE;
            end else begin
              cmd.heap_rd     = 1'b1;
              cmd.heap_rd_sel = RD_ROOT;
              state_nxt       = S_DEL1;
            end
          end
          FN_DECREASE: begin
            if (!sts.hit) begin
              cmd.st_load = 1'b1;
              cmd.st_code = ST_KEY;
              state_nxt   = S_DONE;
            end else begin
              cmd.map_rd = 1'b1;
              state_nxt  = S_DEC1;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DEL1: begin
        cmd.root_cap    = 1'b1;
        cmd.heap_rd     = 1'b1;
        cmd.heap_rd_sel = RD_LAST;
        state_nxt       = S_DEL2;
      end
      S_DEL2: begin
        cmd.del_take = 1'b1;
        state_nxt    = sts.last_one ? S_DONE : S_DOWN;
      end
      S_DEC1: begin
        cmd.dec_take    = 1'b1;
        cmd.heap_rd     = 1'b1;
        cmd.heap_rd_sel = RD_MAP;
        state_nxt       = S_DEC2;
      end
      S_DEC2: begin
        if (!sts.dec_ok) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ST_NODEC;
          state_nxt   = S_DONE;
        end else begin
          cmd.set_e = 1'b1;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (sts.p_root) begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.heap_rd     = 1'b1;
          cmd.heap_rd_sel = RD_PARENT;
          state_nxt       = S_UPW;
        end
      end
      S_UPW: begin
        if (sts.up_greater) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DOWN: begin
        if (sts.leaf) begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.heap_rd     = 1'b1;
          cmd.heap_rd_sel = RD_LEFT;
          state_nxt       = S_DNL;
        end
      end
      S_DNL: begin
        cmd.dn_left = 1'b1;
        if (sts.has_right) begin
          cmd.heap_rd     = 1'b1;
          cmd.heap_rd_sel = RD_RIGHT;
          state_nxt       = S_DNR;
        end else begin
          state_nxt = S_DNC;
        end
      end
      S_DNR: begin
        cmd.dn_right = sts.right_smaller;
        state_nxt    = S_DNC;
      end
      S_DNC: begin
        if (sts.down_greater) begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DOWN;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/imh_checker.sv
// Port-level checker for the indexed min-heap, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module imh_checker import imh_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic [KEY_W-1:0]     out_key,
  input wire logic [PRIO_IN_W-1:0] out_priority,
  input wire logic                 present,
  input wire logic [STATUS_W-1:0]  status,
  input wire logic [COUNT_W-1:0]   count
);

  `IMH_ASSERT_NXT(a_busy_after_request, clk, rst_n, in_valid && in_ready, !in_ready)
  `IMH_ASSERT_IMP(a_flag_zero_payload, clk, rst_n, out_valid && (status != ST_OK), (out_key == '0) && (out_priority == '0))
  `IMH_ASSERT_IMP(a_empty_count, clk, rst_n, out_valid && (status == ST_EMPTY), count == '0)
  `IMH_ASSERT_IMP(a_present_ok, clk, rst_n, out_valid && present, (status == ST_OK) && (count != '0))

endmodule

bind indexed_min_heap_decrease_key imh_checker u_imh_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_key      (out_ch.out_key),
  .out_priority (out_ch.out_priority),
  .present      (out_ch.present),
  .status       (out_ch.status),
  .count        (out_ch.count)
);
`default_nettype wire

FILE: test/indexed_min_heap_decrease_key_test.sv
// Testbench: directed and random heap requests checked against a built-in heap predictor
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_decrease_key_test;
  import imh_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]     rkey;
    logic [PRIO_IN_W-1:0] rprio;
    logic                 present;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  imh_in_if  in_ch ();
  imh_out_if out_ch ();

  indexed_min_heap_decrease_key u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  logic [KEY_W-1:0]     hk [1:IMH_MAX_ITEMS];
  logic [PRIO_IN_W-1:0] hp [1:IMH_MAX_ITEMS];
  int unsigned          pos_of [KEY_SPACE];
  int unsigned          n_entries;
  heap_result_t         pending_results[$];
  int                   errors = 0;
  int unsigned          cycles = 0;
  bit                   hold_off = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.item_key = '0;
    in_ch.item_priority = '0;
    out_ch.ready = 1'b0;
    n_entries = 0;
    foreach (pos_of[i]) pos_of[i] = 0;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] tk;
    logic [PRIO_IN_W-1:0] tp;
    tk = hk[a]; tp = hp[a];
    hk[a] = hk[b]; hp[a] = hp[b];
    hk[b] = tk; hp[b] = tp;
    pos_of[hk[a]] = a;
    pos_of[hk[b]] = b;
  endfunction

  function automatic void climb(int unsigned p);
    while (p > 1 && hp[p/2] > hp[p]) begin
      swap_slots(p, p/2);
      p = p / 2;
    end
  endfunction

  function automatic void descend(int unsigned p);
    int unsigned c;
    while (2*p <= n_entries) begin
      c = 2*p;
      if (c < n_entries && hp[c] > hp[c+1]) c++;
      if (!(hp[p] > hp[c])) break;
      swap_slots(p, c);
      p = c;
    end
  endfunction

  function automatic heap_result_t heap_apply(imh_func_t f, logic [7:0] k, logic [31:0] pr);
    heap_result_t r;
    logic [KEY_W-1:0] gone;
    int unsigned p;
    r = '0;
    r.status = ST_OK;
    case (f)
      FN_INSERT: begin
        if (n_entries >= IMH_MAX_ITEMS) r.status = ST_FULL;
        else if (pos_of[k] != 0) r.status = ST_KEY;
        else begin
          n_entries++;
          hk[n_entries] = k; hp[n_entries] = pr; pos_of[k] = n_entries;
          climb(n_entries);
        end
      end
      FN_DELETE: begin
        if (n_entries == 0) r.status = ST_EMPTY;
        else begin
          gone = hk[1];
          r.rkey = gone; r.rprio = hp[1];
          swap_slots(1, n_entries);
          pos_of[gone] = 0;
          n_entries--;
          descend(1);
        end
      end
      FN_DECREASE: begin
        p = pos_of[k];
        if (p == 0 || p > n_entries) r.status = ST_KEY;
        else if (!(pr < hp[p])) r.status = ST_NODEC;
        else begin
          hp[p] = pr;
          climb(p);
        end
      end
      default: r.present = (n_entries != 0 && pos_of[k] != 0);
    endcase
    r.count = n_entries[COUNT_W-1:0];
    return r;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(imh_func_t f, logic [7:0] k, logic [31:0] pr);
    heap_result_t exp_r;
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    exp_r = heap_apply(f, k, pr);
    pending_results.push_back(exp_r);
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.item_key <= k;
    in_ch.item_priority <= pr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("indexed_min_heap_decrease_key_test: errors");
      $finish;
    end
  end

  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) stall_left <= stall_left - 1;
    else if (hold_off) stall_left <= 0;
    else if ($urandom_range(0, 29) == 0) stall_left <= $urandom_range(5, 40);
    else if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
    out_ch.ready <= rst_n && !hold_off && (stall_left <= 1) && ($urandom_range(0, 5) != 0);
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.out_key !== e.rkey) begin
          $error("out_key exp %0d got %0d", e.rkey, out_ch.out_key); errors++;
        end
        if (out_ch.out_priority !== e.rprio) begin
          $error("out_priority exp %0h got %0h", e.rprio, out_ch.out_priority); errors++;
        end
        if (out_ch.present !== e.present) begin
          $error("present exp %0d got %0d", e.present, out_ch.present); errors++;
        end
        if (out_ch.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_ch.status); errors++;
        end
        if (out_ch.count !== e.count) begin
          $error("count exp %0d got %0d", e.count, out_ch.count); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_request(FN_DELETE, 8'd0, 32'd0);
    send_request(FN_CONTAINS, 8'd0, 32'd0);
    send_request(FN_DECREASE, 8'd5, 32'd1);
    send_request(FN_INSERT, 8'd255, 32'hFFFF_FFFF);
    send_request(FN_INSERT, 8'd0, 32'd0);
    send_request(FN_INSERT, 8'd7, 32'd0);
    send_request(FN_INSERT, 8'd255, 32'd3);
    send_request(FN_INSERT, 8'd9, 32'hAAAA_5555);
    send_request(FN_CONTAINS, 8'd255, 32'd0);
    send_request(FN_CONTAINS, 8'd1, 32'd0);
    send_request(FN_DECREASE, 8'd9, 32'hAAAA_5555);
    send_request(FN_DECREASE, 8'd9, 32'hFFFF_FFFF);
    send_request(FN_DECREASE, 8'd255, 32'd0);
    send_request(FN_DECREASE, 8'd33, 32'd0);
    repeat (5) send_request(FN_DELETE, 8'hFF, 32'hFFFF_FFFF);
    send_request(FN_CONTAINS, 8'd255, 32'd0);
  endtask

  task automatic test_full();
    for (int i = 0; i < 256; i++) send_request(FN_INSERT, i[7:0], $urandom);
    send_request(FN_INSERT, 8'd3, 32'd1);
    send_request(FN_CONTAINS, 8'd128, 32'd0);
    for (int i = 0; i < 256; i++) send_request(FN_DELETE, 8'($urandom), 32'd0);
    send_request(FN_DELETE, 8'd0, 32'd0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++) send_request(FN_INSERT, 8'($urandom_range(0, 31)), $urandom);
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  task automatic test_random(int unsigned n);
    imh_func_t f;
    logic [7:0] k;
    logic [31:0] pr;
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      pr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31) : $urandom;
      if (sel < 40) f = FN_INSERT;
      else if (sel < 65) f = FN_DELETE;
      else if (sel < 90) begin
        f = FN_DECREASE;
        if (n_entries != 0 && sel < 85) begin
          k = hk[$urandom_range(1, n_entries)];
          if (hp[pos_of[k]] != 0 && sel < 82) pr = $urandom_range(0, hp[pos_of[k]] - 1);
        end
      end else f = FN_CONTAINS;
      send_request(f, k, pr);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(100);
    test_full();
    test_random(100);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("indexed_min_heap_decrease_key_test: clean");
    else $display("indexed_min_heap_decrease_key_test: errors");
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/imh_pkg.sv
hw/rtl/imh_if.sv
hw/rtl/imh_ram.sv
hw/rtl/imh_dp.sv
hw/rtl/imh_ctrl.sv
hw/rtl/indexed_min_heap_decrease_key.sv
hw/rtl/imh_checker.sv
test/indexed_min_heap_decrease_key_test.sv
